@@ sv/sflr_pkg.sv @@
`default_nettype none

package sflr_pkg;

  // Sizes of the two byte memories.
  localparam int STORE_DEPTH_DEF = 128;
  localparam int PAYLOAD_DEPTH = 256;
  localparam int PAY_AW = $clog2(PAYLOAD_DEPTH);

  // Register reset values.
  localparam logic [7:0] STORE_LIMIT_RST = 8'd90;
  localparam logic [7:0] COND_HEADER_RST = 8'd0;

  // Frame sync pattern "pe" and the command prefix "CMD".
  localparam logic [7:0] SYNC_0 = 8'h70;
  localparam logic [7:0] SYNC_1 = 8'h65;
  localparam logic [7:0] CMD_0 = 8'h43;
  localparam logic [7:0] CMD_1 = 8'h4D;
  localparam logic [7:0] CMD_2 = 8'h44;
  localparam int CMD_LEN = 6;

  // Configuration register indexes.
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_STORE_LIMIT = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_COND_HEADER = 1'b1;

  typedef enum logic [1:0] {
    OP_BYTE  = 2'd0,
    OP_READ  = 2'd1,
    OP_CLEAR = 2'd2
  } opcode_t;

  typedef enum logic [2:0] {
    EV_NONE     = 3'd0,
    EV_STORED   = 3'd1,
    EV_CMD      = 3'd2,
    EV_BADSUM   = 3'd3,
    EV_OVERSIZE = 3'd4
  } event_t;

  // Requests from the frame parser to the byte memories.
  typedef struct packed {
    logic              pay_we;
    logic [PAY_AW-1:0] pay_addr;
    logic [7:0]        pay_data;
    logic              copy_start;
    logic [7:0]        copy_len;
  } sflr_ctrl_t;

endpackage

`default_nettype wire

@@ sv/sflr_store.sv @@
`default_nettype none

module sflr_store #(
  parameter int STORE_DEPTH = sflr_pkg::STORE_DEPTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  sflr_pkg::sflr_ctrl_t           ctrl,
  input  logic [$clog2(STORE_DEPTH)-1:0] copy_base,
  input  logic [$clog2(STORE_DEPTH)-1:0] rd_addr,
  output logic [7:0]                     rd_data,
  output logic                           busy
);
  import sflr_pkg::*;

  localparam int SA_W = $clog2(STORE_DEPTH);
  localparam int SUM_W = ((SA_W > PAY_AW) ? SA_W : PAY_AW) + 1;

  logic [7:0]        payload_buf [PAYLOAD_DEPTH];
  logic [7:0]        data_store [STORE_DEPTH];
  logic [7:0]        pb_q;
  logic [PAY_AW-1:0] cp_idx;
  logic [7:0]        cp_len;
  logic [SA_W-1:0]   cp_base;
  logic              wr_pend;
  logic [SA_W-1:0]   wr_addr;
  logic [SUM_W-1:0]  wr_sum;

  assign wr_sum = SUM_W'(cp_base) + SUM_W'(cp_idx);

  // Payload buffer: written by the parser, read one byte a cycle by the copy.
  always_ff @(posedge clk) begin
    if (ctrl.pay_we) begin
      payload_buf[ctrl.pay_addr] <= ctrl.pay_data;
    end
    pb_q <= payload_buf[cp_idx];
  end

  // Data store: written by the copy, read for stored-byte requests.
  always_ff @(posedge clk) begin
    if (wr_pend) begin
      data_store[wr_addr] <= pb_q;
    end
    rd_data <= data_store[rd_addr];
  end

  // Copy sequencer: read a payload byte, write it to the store in the next cycle.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy    <= 1'b0;
      wr_pend <= 1'b0;
      cp_idx  <= '0;
    end else if (ctrl.copy_start) begin
      busy    <= 1'b1;
      wr_pend <= 1'b0;
      cp_idx  <= '0;
      cp_len  <= ctrl.copy_len;
      cp_base <= copy_base;
    end else if (busy) begin
      if (cp_idx != cp_len) begin
        wr_pend <= 1'b1;
        wr_addr <= wr_sum[SA_W-1:0];
        cp_idx  <= cp_idx + PAY_AW'(1);
      end else begin
        wr_pend <= 1'b0;
        if (!wr_pend) begin
          busy <= 1'b0;
        end
      end
    end
  end

endmodule

`default_nettype wire

@@ sv/sync_framed_lrc_receiver.sv @@
// Framed link receiver. Each input beat carries one received byte, a request to read
// one byte of the data store, or a request to clear the store; each beat yields one
// result beat with the event, the latest frame id, the link id, the store fill and
// the byte read. Frames are "pe", a 16-bit big-endian id, a length byte, the payload
// (one byte even when the length is zero) and an XOR checksum over the payload. A
// received byte or a clear goes through the execute and finish states to the result
// register; a store read adds a read state for the registered read of the store
// memory. The checksum byte of a stored frame of nonzero length waits in a copy state
// while the payload moves from the payload buffer to the store one byte per cycle
// through its single read port. No new beat is taken until the current one has
// reached the result register; a waiting result lets the next beat in, then stalls it.
`default_nettype none

module sync_framed_lrc_receiver #(
  parameter int STORE_DEPTH = sflr_pkg::STORE_DEPTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [1:0]                     opcode,
  input  logic [7:0]                     rx_byte,
  input  logic [6:0]                     read_index,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [2:0]                     event_res,
  output logic [7:0]                     command_code,
  output logic [15:0]                    command_param,
  output logic [15:0]                    frame_id,
  output logic [15:0]                    link_id,
  output logic [7:0]                     store_length,
  output logic [7:0]                     read_data,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [sflr_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [7:0]                     cfg_data
);
  import sflr_pkg::*;

  localparam int SA_W = $clog2(STORE_DEPTH);
  localparam int SC_W = $clog2(STORE_DEPTH + 1);
  localparam int LIM_W = (SC_W > 8) ? SC_W : 8;
  localparam int CW = LIM_W + 1;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_EXEC = 5'b00010,
    S_READ = 5'b00100,
    S_COPY = 5'b01000,
    S_FIN  = 5'b10000
  } state_t;

  typedef enum logic [4:0] {
    PH_SYNC = 5'b00001,
    PH_ID   = 5'b00010,
    PH_LEN  = 5'b00100,
    PH_PAY  = 5'b01000,
    PH_LRC  = 5'b10000
  } phase_t;

  state_t          state, state_next;
  phase_t          phase, phase_next;
  logic [7:0]      byte_count, byte_count_next;
  logic [7:0]      id_hi, id_hi_next;
  logic [15:0]     id_reg, id_reg_next;
  logic [7:0]      length_reg, length_reg_next;
  logic [7:0]      check_reg, check_reg_next;
  logic [15:0]     link_reg, link_reg_next;
  logic [SC_W-1:0] store_count, store_count_next;
  logic [7:0]      store_limit, cond_header;
  logic [7:0]      cmd_b [CMD_LEN];
  logic [7:0]      cmd_next [CMD_LEN];

  opcode_t         op_q;
  logic [7:0]      byte_q;
  logic [6:0]      idx_q;
  event_t          ev_q, ev_next;
  logic [7:0]      code_q, code_next;
  logic [15:0]     param_q, param_next;
  logic [7:0]      rd_q, rd_next;

  sflr_ctrl_t      ctrl;
  logic [SA_W-1:0] copy_base;
  logic [SA_W-1:0] rd_addr;
  logic [7:0]      rd_data;
  logic            copy_busy;

  logic [7:0]      bc;
  logic [7:0]      pos;
  logic [CW-1:0]   lim, limit_ext, depth_c, len_ext, sc_ext, base_ext, idx_ext, new_sc;
  logic            overflow, oversize, is_cmd, read_hit;

  sflr_store #(
    .STORE_DEPTH (STORE_DEPTH)
  ) u_store (
    .clk       (clk),
    .rst       (rst),
    .ctrl      (ctrl),
    .copy_base (copy_base),
    .rd_addr   (rd_addr),
    .rd_data   (rd_data),
    .busy      (copy_busy)
  );

  assign in_ready  = (state == S_IDLE);
  assign cfg_ready = 1'b1;

  // Frame accept decisions: limit in force, oversize, overflow and command match; read hit.
  always_comb begin
    limit_ext = CW'(store_limit);
    depth_c   = CW'(STORE_DEPTH);
    lim       = (limit_ext > depth_c) ? depth_c : limit_ext;
    len_ext   = CW'(length_reg);
    sc_ext    = CW'(store_count);
    oversize  = len_ext > lim;
    overflow  = (sc_ext + len_ext) > lim;
    base_ext  = overflow ? '0 : sc_ext;
    new_sc    = base_ext + len_ext;
    is_cmd    = (length_reg == 8'(CMD_LEN)) && (cmd_b[0] == CMD_0) &&
                (cmd_b[1] == CMD_1) && (cmd_b[2] == CMD_2);
    idx_ext   = CW'(idx_q);
    read_hit  = (idx_ext < sc_ext) && (idx_ext < depth_c);
  end

  assign rd_addr = idx_ext[SA_W-1:0];
  assign bc      = byte_count + 8'd1;
  assign pos     = bc - 8'd1;

  // Sequencer and byte parser.
  always_comb begin
    state_next       = state;
    phase_next       = phase;
    byte_count_next  = byte_count;
    id_hi_next       = id_hi;
    id_reg_next      = id_reg;
    length_reg_next  = length_reg;
    check_reg_next   = check_reg;
    link_reg_next    = link_reg;
    store_count_next = store_count;
    cmd_next         = cmd_b;
    ev_next          = ev_q;
    code_next        = code_q;
    param_next       = param_q;
    rd_next          = rd_q;
    ctrl             = '0;
    copy_base        = base_ext[SA_W-1:0];

    case (state)
      S_IDLE: begin
        if (in_valid) begin
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        ev_next    = EV_NONE;
        code_next  = '0;
        param_next = '0;
        rd_next    = '0;
        state_next = S_FIN;
        case (op_q)
          OP_BYTE: begin
            byte_count_next = bc;
            case (phase)
              PH_SYNC: begin
                if (bc == 8'd1) begin
                  if (byte_q != SYNC_0) begin
                    byte_count_next = '0;
                  end
                end else begin
                  byte_count_next = '0;
                  if (byte_q == SYNC_1) begin
                    phase_next = PH_ID;
                  end
                end
              end
              PH_ID: begin
                if (bc == 8'd1) begin
                  id_hi_next = byte_q;
                end else begin
                  id_reg_next     = {id_hi, byte_q};
                  byte_count_next = '0;
                  phase_next      = PH_LEN;
                end
              end
              PH_LEN: begin
                check_reg_next  = '0;
                length_reg_next = byte_q;
                byte_count_next = '0;
                phase_next      = PH_PAY;
              end
              PH_PAY: begin
                if ((bc == 8'd1) && (byte_q == cond_header)) begin
                  link_reg_next = id_reg;
                end
                check_reg_next = check_reg ^ byte_q;
                ctrl.pay_we    = 1'b1;
                ctrl.pay_addr  = pos;
                ctrl.pay_data  = byte_q;
                if (pos < 8'(CMD_LEN)) begin
                  cmd_next[pos[2:0]] = byte_q;
                end
                if (bc >= length_reg) begin
                  byte_count_next = '0;
                  phase_next      = PH_LRC;
                end
              end
              PH_LRC: begin
                byte_count_next = '0;
                phase_next      = PH_SYNC;
                if (check_reg != byte_q) begin
                  ev_next = EV_BADSUM;
                end else if (is_cmd) begin
                  ev_next    = EV_CMD;
                  code_next  = cmd_b[3];
                  param_next = {cmd_b[4], cmd_b[5]};
                end else if (oversize) begin
                  ev_next = EV_OVERSIZE;
                end else begin
                  ev_next          = EV_STORED;
                  store_count_next = new_sc[SC_W-1:0];
                  if (length_reg != 8'd0) begin
                    ctrl.copy_start = 1'b1;
                    ctrl.copy_len   = length_reg;
                    state_next      = S_COPY;
                  end
                end
              end
              default: begin
                byte_count_next = '0;
                phase_next      = PH_SYNC;
              end
            endcase
          end
          OP_READ: begin
            state_next = S_READ;
          end
          OP_CLEAR: begin
            store_count_next = '0;
          end
          default: begin
          end
        endcase
      end
      S_READ: begin
        rd_next    = read_hit ? rd_data : 8'd0;
        state_next = S_FIN;
      end
      S_COPY: begin
        if (!copy_busy) begin
          state_next = S_FIN;
        end
      end
      S_FIN: begin
        if (!out_valid || out_ready) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Control state and configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      phase       <= PH_SYNC;
      byte_count  <= '0;
      id_hi       <= '0;
      id_reg      <= '0;
      length_reg  <= '0;
      check_reg   <= '0;
      link_reg    <= '0;
      store_count <= '0;
      store_limit <= STORE_LIMIT_RST;
      cond_header <= COND_HEADER_RST;
      out_valid   <= 1'b0;
    end else begin
      state       <= state_next;
      phase       <= phase_next;
      byte_count  <= byte_count_next;
      id_hi       <= id_hi_next;
      id_reg      <= id_reg_next;
      length_reg  <= length_reg_next;
      check_reg   <= check_reg_next;
      link_reg    <= link_reg_next;
      store_count <= store_count_next;
      if (cfg_valid) begin
        case (cfg_index)
          REG_STORE_LIMIT: store_limit <= cfg_data;
          REG_COND_HEADER: cond_header <= cfg_data;
          default: begin
          end
        endcase
      end
      if ((state == S_FIN) && (!out_valid || out_ready)) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Beat capture, working result and the output register.
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      op_q   <= opcode_t'(opcode);
      byte_q <= rx_byte;
      idx_q  <= read_index;
    end
    cmd_b   <= cmd_next;
    ev_q    <= ev_next;
    code_q  <= code_next;
    param_q <= param_next;
    rd_q    <= rd_next;
    if ((state == S_FIN) && (!out_valid || out_ready)) begin
      event_res     <= ev_q;
      command_code  <= code_q;
      command_param <= param_q;
      frame_id      <= id_reg;
      link_id       <= link_reg;
      store_length  <= sc_ext[7:0];
      read_data     <= rd_q;
    end
  end

endmodule

`default_nettype wire

@@ sv/sflr_checker.sv @@
`default_nettype none

module sflr_checker (
  input logic                           clk,
  input logic                           rst,
  input logic                           in_valid,
  input logic                           in_ready,
  input logic [1:0]                     opcode,
  input logic [7:0]                     rx_byte,
  input logic [6:0]                     read_index,
  input logic                           out_valid,
  input logic                           out_ready,
  input logic [2:0]                     event_res,
  input logic [7:0]                     command_code,
  input logic [15:0]                    command_param,
  input logic [15:0]                    frame_id,
  input logic [15:0]                    link_id,
  input logic [7:0]                     store_length,
  input logic [7:0]                     read_data
);
  import sflr_pkg::*;

  // A stalled input beat holds.
  a_in_hold: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_ready |=> in_valid && $stable(opcode) && $stable(rx_byte) &&
    $stable(read_index))
    else $error("input beat changed while stalled");

  // A stalled result beat holds.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(event_res) &&
    $stable(frame_id) && $stable(link_id) && $stable(store_length))
    else $error("result beat changed while stalled");

  // One beat at a time: the input side closes right after an acceptance.
  a_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("second beat accepted while busy");

  // Command fields are zero unless the result is a command.
  a_cmd_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && (event_res != EV_CMD) |-> (command_code == 8'd0) &&
    (command_param == 16'd0))
    else $error("command fields set on a non-command result");

  // Frame events never carry read data.
  a_read_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && (event_res != EV_NONE) |-> (read_data == 8'd0))
    else $error("read data set on a frame event");

endmodule

bind sync_framed_lrc_receiver sflr_checker u_sflr_checker (.*);

`default_nettype wire
